// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of this folder.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked every clock, masked while reset is asserted.
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/dhcp_rp_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the DHCP reply parser.
// No dependencies; used by dhcp_reply_parser_core.
package dhcp_rp_pkg;

	// options area size in bytes
	localparam int unsigned OPTION_BYTES = 60;
	localparam int unsigned OPTS_START   = 240;
	localparam int unsigned PKT_BYTES    = OPTS_START + OPTION_BYTES;
	localparam int unsigned POS_W        = $clog2(PKT_BYTES + 1);

	typedef logic [POS_W-1:0] pos_t;

	// header byte positions
	localparam pos_t POS_OP        = pos_t'(0);
	localparam pos_t POS_XID_LO    = pos_t'(4);
	localparam pos_t POS_XID_HI    = pos_t'(7);
	localparam pos_t POS_YI_LO     = pos_t'(16);
	localparam pos_t POS_YI_HI     = pos_t'(19);
	localparam pos_t POS_SI_LO     = pos_t'(20);
	localparam pos_t POS_SI_HI     = pos_t'(23);
	localparam pos_t POS_MAC_LO    = pos_t'(28);
	localparam pos_t POS_MAC_HI    = pos_t'(33);
	localparam pos_t POS_FILE      = pos_t'(108);
	localparam pos_t POS_COOKIE_LO = pos_t'(236);
	localparam pos_t POS_COOKIE_HI = pos_t'(239);
	localparam pos_t POS_OPTS      = pos_t'(OPTS_START);
	localparam pos_t POS_END       = pos_t'(PKT_BYTES);

	localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
	localparam logic [7:0]  OP_REPLY     = 8'd2;

	// option codes
	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_MASK     = 8'd1;
	localparam logic [7:0] OPT_ROUTER   = 8'd3;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER   = 8'd54;
	localparam logic [7:0] OPT_END      = 8'd255;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_OP    = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_BAD_XID   = 3'd3;
	localparam logic [2:0] ST_BAD_HW    = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_XID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAC = 2'd1;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        last;
		logic [31:0] source_ip;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  message_type;
		logic [31:0] your_ip;
		logic [31:0] next_server;
		logic [31:0] subnet_mask;
		logic        mask_present;
		logic [31:0] router_addr;
		logic        router_present;
		logic [31:0] server_id;
		logic        server_id_present;
		logic        file_present;
	} out_word_t;

endpackage

// File: hw/rtl/dhcp_reply_parser_core.sv
`timescale 1ns / 1ps
// DHCP reply parser top level: header checks, address capture, option walk.
// Depends on dhcp_rp_pkg and assert_macros.svh.
//
// Takes a BOOTP/DHCP reply one byte per word on the byte channel, marked
// on the final byte, and returns one result word per packet on the result
// channel. One byte is taken every cycle unless a final byte stalls: the word
// is held in an input register, then the per-packet state (position counter,
// mismatch flags, option walker, captured addresses) is updated by a single
// position-indexed pass. The result is loaded into an output register the
// cycle the final byte leaves the input register, so it passes the input
// and output registers in turn. The only stall: a final byte waits in the
// input register while the previous result has not been taken, since the
// result register is the one place the packet summary can go. Checks are
// reported first-fail in order opcode, cookie, xid, hardware address; a
// packet shorter than the fixed header reports truncated. On any error the
// other result fields read zero. The option walk stops at the end of the
// options area or on the end option; short values are zero filled, long
// ones keep their first four bytes, repeated options keep the last one.
// There is no clearing pass after reset. Write transaction_id and
// mac_address only between packets.
`include "assert_macros.svh"

module dhcp_reply_parser_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// byte channel
	input  logic                                  byte_valid,
	output logic                                  byte_ready,
	input  dhcp_rp_pkg::in_word_t                 byte_word,
	// result channel
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output dhcp_rp_pkg::out_word_t                result_word,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [dhcp_rp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [47:0]                           cfg_data
);

	// option walker phases
	localparam logic [1:0] PH_CODE  = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_ENDED = 2'd3;

	// config
	logic [31:0] xid_q;
	logic [47:0] mac_q;

	// input stage
	logic                  valid_s1;
	dhcp_rp_pkg::in_word_t word_s1;
	logic                  advance_s1;

	// per-packet state
	dhcp_rp_pkg::pos_t pos_q, pos_nxt;
	logic        bad_op_q, bad_op_nxt;
	logic        bad_ck_q, bad_ck_nxt;
	logic        bad_xid_q, bad_xid_nxt;
	logic        bad_hw_q, bad_hw_nxt;
	logic [1:0]  phase_q, phase_nxt;
	logic [7:0]  code_q, code_nxt;
	logic [7:0]  remain_q, remain_nxt;
	logic [2:0]  vidx_q, vidx_nxt;      // value byte index, saturates at 4
	logic [31:0] yi_q, yi_nxt;
	logic [31:0] si_q, si_nxt;
	logic        file_q, file_nxt;
	logic [7:0]  type_q, type_nxt;
	logic [31:0] mask_q, mask_nxt;
	logic [31:0] rtr_q, rtr_nxt;
	logic [31:0] sid_q, sid_nxt;
	logic        mask_seen_q, mask_seen_nxt;
	logic        rtr_seen_q, rtr_seen_nxt;
	logic        sid_seen_q, sid_seen_nxt;

	// output register
	logic                   result_valid_q;
	dhcp_rp_pkg::out_word_t result_q;
	dhcp_rp_pkg::out_word_t result_nxt;

	logic [7:0]  b;
	logic [7:0]  xid_byte, mac_byte, ck_byte;
	logic [2:0]  mac_idx;
	logic [31:0] part;
	logic [2:0]  status;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q <= '0;
			mac_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == dhcp_rp_pkg::CFG_XID) begin
				xid_q <= cfg_data[31:0];
			end else if (cfg_index == dhcp_rp_pkg::CFG_MAC) begin
				mac_q <= cfg_data;
			end
		end
	end

	// ---------------------------------------------------------------
	// Input register. Non-final bytes always move on; a final byte
	// needs the result register free (or being emptied).
	// ---------------------------------------------------------------
	assign advance_s1 = valid_s1 && (!word_s1.last || !result_valid_q || result_ready);
	assign byte_ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			word_s1 <= byte_word;
		end
	end

	// ---------------------------------------------------------------
	// Expected header bytes selected by position
	// ---------------------------------------------------------------
	assign b       = word_s1.rx_byte;
	assign mac_idx = 3'(pos_q - dhcp_rp_pkg::POS_MAC_LO);

	always_comb begin
		case (pos_q[1:0])
			2'd0:    xid_byte = xid_q[31:24];
			2'd1:    xid_byte = xid_q[23:16];
			2'd2:    xid_byte = xid_q[15:8];
			default: xid_byte = xid_q[7:0];
		endcase
		case (pos_q[1:0])
			2'd0:    ck_byte = dhcp_rp_pkg::MAGIC_COOKIE[31:24];
			2'd1:    ck_byte = dhcp_rp_pkg::MAGIC_COOKIE[23:16];
			2'd2:    ck_byte = dhcp_rp_pkg::MAGIC_COOKIE[15:8];
			default: ck_byte = dhcp_rp_pkg::MAGIC_COOKIE[7:0];
		endcase
		case (mac_idx)
			3'd0:    mac_byte = mac_q[47:40];
			3'd1:    mac_byte = mac_q[39:32];
			3'd2:    mac_byte = mac_q[31:24];
			3'd3:    mac_byte = mac_q[23:16];
			3'd4:    mac_byte = mac_q[15:8];
			default: mac_byte = mac_q[7:0];
		endcase
		// value byte placed in its lane, first byte most significant
		case (vidx_q[1:0])
			2'd0:    part = {b, 24'h0};
			2'd1:    part = {8'h0, b, 16'h0};
			2'd2:    part = {16'h0, b, 8'h0};
			default: part = {24'h0, b};
		endcase
	end

	// ---------------------------------------------------------------
	// Per-byte update
	// ---------------------------------------------------------------
	always_comb begin
		pos_nxt       = pos_q;
		bad_op_nxt    = bad_op_q;
		bad_ck_nxt    = bad_ck_q;
		bad_xid_nxt   = bad_xid_q;
		bad_hw_nxt    = bad_hw_q;
		phase_nxt     = phase_q;
		code_nxt      = code_q;
		remain_nxt    = remain_q;
		vidx_nxt      = vidx_q;
		yi_nxt        = yi_q;
		si_nxt        = si_q;
		file_nxt      = file_q;
		type_nxt      = type_q;
		mask_nxt      = mask_q;
		rtr_nxt       = rtr_q;
		sid_nxt       = sid_q;
		mask_seen_nxt = mask_seen_q;
		rtr_seen_nxt  = rtr_seen_q;
		sid_seen_nxt  = sid_seen_q;

		if (pos_q < dhcp_rp_pkg::POS_END) begin
			pos_nxt = pos_q + 1'b1;
			if (pos_q == dhcp_rp_pkg::POS_OP) begin
				bad_op_nxt = (b != dhcp_rp_pkg::OP_REPLY);
			end else if (pos_q >= dhcp_rp_pkg::POS_XID_LO &&
			             pos_q <= dhcp_rp_pkg::POS_XID_HI) begin
				if (b != xid_byte) bad_xid_nxt = 1'b1;
			end else if (pos_q >= dhcp_rp_pkg::POS_YI_LO &&
			             pos_q <= dhcp_rp_pkg::POS_YI_HI) begin
				yi_nxt = {yi_q[23:0], b};
			end else if (pos_q >= dhcp_rp_pkg::POS_SI_LO &&
			             pos_q <= dhcp_rp_pkg::POS_SI_HI) begin
				si_nxt = {si_q[23:0], b};
			end else if (pos_q >= dhcp_rp_pkg::POS_MAC_LO &&
			             pos_q <= dhcp_rp_pkg::POS_MAC_HI) begin
				if (b != mac_byte) bad_hw_nxt = 1'b1;
			end else if (pos_q == dhcp_rp_pkg::POS_FILE) begin
				file_nxt = (b != 8'd0);
			end else if (pos_q >= dhcp_rp_pkg::POS_COOKIE_LO &&
			             pos_q <= dhcp_rp_pkg::POS_COOKIE_HI) begin
				if (b != ck_byte) bad_ck_nxt = 1'b1;
			end else if (pos_q >= dhcp_rp_pkg::POS_OPTS) begin
				case (phase_q)
					PH_CODE: begin
						if (b == dhcp_rp_pkg::OPT_END) begin
							phase_nxt = PH_ENDED;
						end else if (b != dhcp_rp_pkg::OPT_PAD) begin
							code_nxt  = b;
							phase_nxt = PH_LEN;
						end
					end
					PH_LEN: begin
						remain_nxt = b;
						vidx_nxt   = 3'd0;
						phase_nxt  = (b != 8'd0) ? PH_VALUE : PH_CODE;
						if (code_q == dhcp_rp_pkg::OPT_MSG_TYPE) begin
							type_nxt = 8'd0;
						end else if (code_q == dhcp_rp_pkg::OPT_MASK) begin
							mask_nxt      = '0;
							mask_seen_nxt = 1'b1;
						end else if (code_q == dhcp_rp_pkg::OPT_ROUTER) begin
							rtr_nxt      = '0;
							rtr_seen_nxt = 1'b1;
						end else if (code_q == dhcp_rp_pkg::OPT_SERVER) begin
							sid_nxt      = '0;
							sid_seen_nxt = 1'b1;
						end
					end
					PH_VALUE: begin
						if (code_q == dhcp_rp_pkg::OPT_MSG_TYPE) begin
							if (vidx_q == 3'd0) type_nxt = b;
						end else if (!vidx_q[2]) begin
							if (code_q == dhcp_rp_pkg::OPT_MASK) begin
								mask_nxt = mask_q | part;
							end else if (code_q == dhcp_rp_pkg::OPT_ROUTER) begin
								rtr_nxt = rtr_q | part;
							end else if (code_q == dhcp_rp_pkg::OPT_SERVER) begin
								sid_nxt = sid_q | part;
							end
						end
						if (!vidx_q[2]) vidx_nxt = vidx_q + 3'd1;
						remain_nxt = remain_q - 8'd1;
						if (remain_q == 8'd1) phase_nxt = PH_CODE;
					end
					default: begin
						// end option seen: rest ignored
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// Result from the state after the final byte
	// ---------------------------------------------------------------
	always_comb begin
		if (pos_nxt < dhcp_rp_pkg::POS_OPTS) status = dhcp_rp_pkg::ST_TRUNC;
		else if (bad_op_nxt)                  status = dhcp_rp_pkg::ST_BAD_OP;
		else if (bad_ck_nxt)                  status = dhcp_rp_pkg::ST_BAD_MAGIC;
		else if (bad_xid_nxt)                 status = dhcp_rp_pkg::ST_BAD_XID;
		else if (bad_hw_nxt)                  status = dhcp_rp_pkg::ST_BAD_HW;
		else                                  status = dhcp_rp_pkg::ST_OK;

		result_nxt        = '0;
		result_nxt.status = status;
		if (status == dhcp_rp_pkg::ST_OK) begin
			result_nxt.message_type      = type_nxt;
			result_nxt.your_ip           = yi_nxt;
			result_nxt.next_server       = file_nxt ? si_nxt : word_s1.source_ip;
			result_nxt.subnet_mask       = mask_nxt;
			result_nxt.mask_present      = mask_seen_nxt;
			result_nxt.router_addr       = rtr_nxt;
			result_nxt.router_present    = rtr_seen_nxt;
			result_nxt.server_id         = sid_nxt;
			result_nxt.server_id_present = sid_seen_nxt;
			result_nxt.file_present      = file_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Packet state registers; cleared after the final byte
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			bad_op_q    <= 1'b0;
			bad_ck_q    <= 1'b0;
			bad_xid_q   <= 1'b0;
			bad_hw_q    <= 1'b0;
			phase_q     <= PH_CODE;
			code_q      <= '0;
			remain_q    <= '0;
			vidx_q      <= '0;
			yi_q        <= '0;
			si_q        <= '0;
			file_q      <= 1'b0;
			type_q      <= '0;
			mask_q      <= '0;
			rtr_q       <= '0;
			sid_q       <= '0;
			mask_seen_q <= 1'b0;
			rtr_seen_q  <= 1'b0;
			sid_seen_q  <= 1'b0;
		end else if (advance_s1) begin
			if (word_s1.last) begin
				pos_q       <= '0;
				bad_op_q    <= 1'b0;
				bad_ck_q    <= 1'b0;
				bad_xid_q   <= 1'b0;
				bad_hw_q    <= 1'b0;
				phase_q     <= PH_CODE;
				code_q      <= '0;
				remain_q    <= '0;
				vidx_q      <= '0;
				yi_q        <= '0;
				si_q        <= '0;
				file_q      <= 1'b0;
				type_q      <= '0;
				mask_q      <= '0;
				rtr_q       <= '0;
				sid_q       <= '0;
				mask_seen_q <= 1'b0;
				rtr_seen_q  <= 1'b0;
				sid_seen_q  <= 1'b0;
			end else begin
				pos_q       <= pos_nxt;
				bad_op_q    <= bad_op_nxt;
				bad_ck_q    <= bad_ck_nxt;
				bad_xid_q   <= bad_xid_nxt;
				bad_hw_q    <= bad_hw_nxt;
				phase_q     <= phase_nxt;
				code_q      <= code_nxt;
				remain_q    <= remain_nxt;
				vidx_q      <= vidx_nxt;
				yi_q        <= yi_nxt;
				si_q        <= si_nxt;
				file_q      <= file_nxt;
				type_q      <= type_nxt;
				mask_q      <= mask_nxt;
				rtr_q       <= rtr_nxt;
				sid_q       <= sid_nxt;
				mask_seen_q <= mask_seen_nxt;
				rtr_seen_q  <= rtr_seen_nxt;
				sid_seen_q  <= sid_seen_nxt;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance_s1 && word_s1.last) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && word_s1.last) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`ASSERT_CHK(a_pos_bound, clk, arst_n, pos_q <= dhcp_rp_pkg::POS_END)
	`ASSERT_IMP(a_stall_cause, clk, arst_n, !byte_ready,
		valid_s1 && word_s1.last && result_valid_q && !result_ready)
	`ASSERT_NXT(a_last_clears, clk, arst_n, advance_s1 && word_s1.last,
		pos_q == '0 && phase_q == PH_CODE && result_valid_q)
	`ASSERT_IMP(a_err_zero, clk, arst_n,
		result_valid_q && result_q.status != dhcp_rp_pkg::ST_OK,
		result_q.your_ip == '0 && result_q.next_server == '0 &&
		!result_q.mask_present && !result_q.file_present)
	`ASSERT_IMP(a_status_code, clk, arst_n, result_valid_q,
		result_q.status <= dhcp_rp_pkg::ST_TRUNC)

endmodule

// File: verif/dhcp_reply_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the DHCP reply parser: predicts one result word per packet
// and compares it with the result channel. Depends on dhcp_rp_pkg.
module dhcp_reply_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	input  logic                              byte_ready,
	input  dhcp_rp_pkg::in_word_t             byte_word,
	input  logic                              result_valid,
	input  logic                              result_ready,
	input  dhcp_rp_pkg::out_word_t            result_word,
	input  logic                              cfg_we,
	input  logic [dhcp_rp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [47:0]                       cfg_data,
	output int                                fail_count,
	output int                                replies_pending
);
	import dhcp_rp_pkg::*;

	localparam int PRINT_CAP = 200;

	typedef enum logic [1:0] {WALK_CODE, WALK_LEN, WALK_VALUE, WALK_DONE} walk_t;

	logic [31:0] xid_reg;
	logic [47:0] mac_reg;

	int unsigned pos;
	logic        op_bad, cookie_bad, xid_bad, hw_bad;
	walk_t       walk;
	logic [7:0]  cur_code, left;
	int unsigned val_idx;
	logic [31:0] yi_addr, si_addr;
	logic        file_nz;
	logic [7:0]  mtype;
	logic [31:0] mask_v, rtr_v, sid_v;
	logic        mask_p, rtr_p, sid_p;

	out_word_t reply_due_q[$];
	int        errors = 0;

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		if (errors < PRINT_CAP)
			$display("%0t dhcp reply mismatch on %s: got %0h, want %0h",
				$time, what, got, want);
		errors++;
	endtask

	function automatic void clear_reply_state();
		pos = 0;
		op_bad = 1'b0;
		cookie_bad = 1'b0;
		xid_bad = 1'b0;
		hw_bad = 1'b0;
		walk = WALK_CODE;
		cur_code = '0;
		left = '0;
		val_idx = 0;
		yi_addr = '0;
		si_addr = '0;
		file_nz = 1'b0;
		mtype = '0;
		mask_v = '0;
		rtr_v = '0;
		sid_v = '0;
		mask_p = 1'b0;
		rtr_p = 1'b0;
		sid_p = 1'b0;
	endfunction

	// one accepted byte; queues the expected result on the final byte
	function automatic void parse_reply_byte(input in_word_t w);
		logic [7:0]  b;
		logic [31:0] part;
		out_word_t   r;
		b = w.rx_byte;
		if (pos < PKT_BYTES) begin
			if (pos == POS_OP) begin
				op_bad = (b != OP_REPLY);
			end else if (pos >= POS_XID_LO && pos <= POS_XID_HI) begin
				if (xid_reg[8*(POS_XID_HI - pos) +: 8] != b)
					xid_bad = 1'b1;
			end else if (pos >= POS_YI_LO && pos <= POS_YI_HI) begin
				yi_addr = {yi_addr[23:0], b};
			end else if (pos >= POS_SI_LO && pos <= POS_SI_HI) begin
				si_addr = {si_addr[23:0], b};
			end else if (pos >= POS_MAC_LO && pos <= POS_MAC_HI) begin
				if (mac_reg[8*(POS_MAC_HI - pos) +: 8] != b)
					hw_bad = 1'b1;
			end else if (pos == POS_FILE) begin
				file_nz = (b != 8'd0);
			end else if (pos >= POS_COOKIE_LO && pos <= POS_COOKIE_HI) begin
				if (MAGIC_COOKIE[8*(POS_COOKIE_HI - pos) +: 8] != b)
					cookie_bad = 1'b1;
			end else if (pos >= POS_OPTS) begin
				case (walk)
				WALK_CODE: begin
					if (b == OPT_END)
						walk = WALK_DONE;
					else if (b != OPT_PAD) begin
						cur_code = b;
						walk = WALK_LEN;
					end
				end
				WALK_LEN: begin
					left = b;
					val_idx = 0;
					case (cur_code)
					OPT_MSG_TYPE: mtype = '0;
					OPT_MASK: begin
						mask_v = '0;
						mask_p = 1'b1;
					end
					OPT_ROUTER: begin
						rtr_v = '0;
						rtr_p = 1'b1;
					end
					OPT_SERVER: begin
						sid_v = '0;
						sid_p = 1'b1;
					end
					default: ;
					endcase
					walk = (b != 8'd0) ? WALK_VALUE : WALK_CODE;
				end
				WALK_VALUE: begin
					if (cur_code == OPT_MSG_TYPE) begin
						if (val_idx == 0)
							mtype = b;
					end else if (val_idx < 4) begin
						part = {24'd0, b} << (24 - 8 * val_idx);
						case (cur_code)
						OPT_MASK:   mask_v = mask_v | part;
						OPT_ROUTER: rtr_v = rtr_v | part;
						OPT_SERVER: sid_v = sid_v | part;
						default: ;
						endcase
					end
					val_idx++;
					left = left - 8'd1;
					if (left == 8'd0)
						walk = WALK_CODE;
				end
				default: ;
				endcase
			end
			pos++;
		end
		if (w.last) begin
			r = '0;
			if (pos < OPTS_START)
				r.status = ST_TRUNC;
			else if (op_bad)
				r.status = ST_BAD_OP;
			else if (cookie_bad)
				r.status = ST_BAD_MAGIC;
			else if (xid_bad)
				r.status = ST_BAD_XID;
			else if (hw_bad)
				r.status = ST_BAD_HW;
			else begin
				r.status = ST_OK;
				r.message_type = mtype;
				r.your_ip = yi_addr;
				r.next_server = file_nz ? si_addr : w.source_ip;
				r.subnet_mask = mask_v;
				r.mask_present = mask_p;
				r.router_addr = rtr_v;
				r.router_present = rtr_p;
				r.server_id = sid_v;
				r.server_id_present = sid_p;
				r.file_present = file_nz;
			end
			reply_due_q.push_back(r);
			clear_reply_state();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			xid_reg = '0;
			mac_reg = '0;
			clear_reply_state();
			reply_due_q.delete();
			replies_pending <= 0;
			fail_count <= errors;
		end else begin
			if (result_valid && result_ready) begin
				if (reply_due_q.size() == 0) begin
					report_mismatch("result with no packet pending", result_word.status, 0);
				end else begin
					want = reply_due_q.pop_front();
					if (result_word.status !== want.status)
						report_mismatch("status", result_word.status, want.status);
					if (result_word.message_type !== want.message_type)
						report_mismatch("message_type", result_word.message_type,
							want.message_type);
					if (result_word.your_ip !== want.your_ip)
						report_mismatch("your_ip", result_word.your_ip, want.your_ip);
					if (result_word.next_server !== want.next_server)
						report_mismatch("next_server", result_word.next_server,
							want.next_server);
					if (result_word.subnet_mask !== want.subnet_mask)
						report_mismatch("subnet_mask", result_word.subnet_mask,
							want.subnet_mask);
					if (result_word.mask_present !== want.mask_present)
						report_mismatch("mask_present", result_word.mask_present,
							want.mask_present);
					if (result_word.router_addr !== want.router_addr)
						report_mismatch("router_addr", result_word.router_addr,
							want.router_addr);
					if (result_word.router_present !== want.router_present)
						report_mismatch("router_present", result_word.router_present,
							want.router_present);
					if (result_word.server_id !== want.server_id)
						report_mismatch("server_id", result_word.server_id, want.server_id);
					if (result_word.server_id_present !== want.server_id_present)
						report_mismatch("server_id_present", result_word.server_id_present,
							want.server_id_present);
					if (result_word.file_present !== want.file_present)
						report_mismatch("file_present", result_word.file_present,
							want.file_present);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_XID)
					xid_reg = cfg_data[31:0];
				else if (cfg_index == CFG_MAC)
					mac_reg = cfg_data;
			end
			if (byte_valid && byte_ready)
				parse_reply_byte(byte_word);
			replies_pending <= reply_due_q.size();
			fail_count <= errors;
		end
	end

endmodule

// File: verif/tb_dhcp_reply_parser_core.sv
`timescale 1ns / 1ps
// Testbench top for dhcp_reply_parser_core: drives reply packets and
// register writes, and gives the verdict. Depends on dhcp_rp_pkg and
// dhcp_reply_checker.
//
// Flow: reset, a directed set of packets (truncation, check priority, every
// option corner), then random packets - mostly well-formed replies with
// random option areas, plus truncated and pure-noise packets - until enough
// results have come back. Registers change only while the block is drained.
module tb_dhcp_reply_parser_core;
	import dhcp_rp_pkg::*;

	localparam int IDLE_PCT           = 34;
	localparam int SINK_HOLD_CYCLES   = 700;   // long enough for two short packets
	localparam int WATCHDOG_LIMIT     = 5000;
	localparam int DRAIN_CYCLES       = 6;     // input reg + result reg, with margin
	localparam int RANDOM_BYTES       = 1550;
	localparam int MIN_RANDOM_REPLIES = 48;

	// index past the register list; the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// boot file name option: not captured, must be skipped by length
	localparam logic [7:0] OPT_BOOT_FILE = 8'd67;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_ready;
	in_word_t             byte_word;
	logic                 result_valid;
	logic                 result_ready;
	out_word_t            result_word;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [47:0]          cfg_data;

	int fail_count;
	int replies_pending;

	// traffic shaping; sink_idle and sink_hold_req are shared with the result sink process
	int   src_idle;
	int   sink_idle;
	logic sink_hold_req;

	// register values last written, used to build replies that pass the checks
	logic [31:0] cur_xid;
	logic [47:0] cur_mac;

	logic [7:0] pkt[$];   // packet under construction
	int         sent_bytes;

	dhcp_reply_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_word    (byte_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	dhcp_reply_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_ready      (byte_ready),
		.byte_word       (byte_word),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result_word     (result_word),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.replies_pending (replies_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ends the run if neither channel moves a word for too long. Covers a
	// hung block as well as a result that never shows up at the end.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (byte_valid && byte_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_dhcp_reply_parser_core: FAIL");
		$finish;
	end

	// Result sink: random ready, idle sink_idle percent of the time, or one long hold-off
	// when asked, counted here so the sender keeps streaming meanwhile.
	initial begin : result_sink
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				result_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				sink_hold_req = 1'b0;
			end
			result_ready <= ($urandom_range(99) >= sink_idle);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has been taken, plus
	// the pipeline depth, so a register write cannot land mid-packet.
	task automatic settle();
		byte_valid <= 1'b0;
		do @(posedge clk); while (replies_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One word on the byte channel. Optional idle cycles go in front; valid
	// then stays up with a fixed payload until the handshake.
	task automatic push_byte(input logic [7:0] b, input logic fin, input logic [31:0] src);
		in_word_t w;
		w.rx_byte = b;
		w.last = fin;
		w.source_ip = src;
		while ($urandom_range(99) < src_idle) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_word <= w;
		byte_valid <= 1'b1;
		do @(posedge clk); while (!byte_ready);
	endtask

	// source_ip only counts on the final byte; the rest carry noise
	task automatic send_packet(input logic [31:0] src);
		for (int i = 0; i < pkt.size(); i++)
			push_byte(pkt[i], i == pkt.size() - 1, (i == pkt.size() - 1) ? src : $urandom());
		sent_bytes += pkt.size();
	endtask

	// Fixed 240-byte header; bytes the block does not look at are random.
	function automatic void build_header(input logic [7:0] op, input logic [31:0] xid,
			input logic [31:0] yi, input logic [31:0] si, input logic [47:0] mac,
			input logic [7:0] file0, input logic [31:0] cookie);
		pkt.delete();
		for (int i = 0; i < OPTS_START; i++)
			pkt.push_back(8'($urandom()));
		pkt[POS_OP] = op;
		for (int k = 0; k < 4; k++) begin
			pkt[POS_XID_LO + k] = xid[8*(3-k) +: 8];
			pkt[POS_YI_LO + k] = yi[8*(3-k) +: 8];
			pkt[POS_SI_LO + k] = si[8*(3-k) +: 8];
			pkt[POS_COOKIE_LO + k] = cookie[8*(3-k) +: 8];
		end
		for (int k = 0; k < 6; k++)
			pkt[POS_MAC_LO + k] = mac[8*(5-k) +: 8];
		pkt[POS_FILE] = file0;
	endfunction

	// code, length, then random value bytes
	function automatic void add_option(input logic [7:0] code, input int len);
		pkt.push_back(code);
		pkt.push_back(8'(len));
		for (int i = 0; i < len; i++)
			pkt.push_back(8'($urandom()));
	endfunction

	initial begin : stimulus
		int         pkt_no;
		int         kind;
		int         target;
		int         n;
		logic [7:0] code;

		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_word = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sink_hold_req = 1'b0;
		src_idle = IDLE_PCT;
		sink_idle = IDLE_PCT;
		cur_xid = '0;
		cur_mac = '0;
		sent_bytes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// registers still at reset value: clean reply with every captured
		// option, empty boot file so next_server is the sender
		build_header(OP_REPLY, cur_xid, $urandom(), $urandom(), cur_mac, 8'd0, MAGIC_COOKIE);
		add_option(OPT_MSG_TYPE, 1);
		add_option(OPT_MASK, 4);
		add_option(OPT_ROUTER, 8);
		add_option(OPT_SERVER, 4);
		pkt.push_back(OPT_END);
		send_packet('1);

		// all-ones registers; the spare index must not disturb them
		settle();
		cur_xid = '1;
		cur_mac = '1;
		write_reg(CFG_XID, '1);
		write_reg(CFG_MAC, cur_mac);
		write_reg(CFG_SPARE, '0);

		// boot file present; pads, zero and short lengths, long values,
		// repeats, a skipped option, and options after the end mark
		build_header(OP_REPLY, cur_xid, '1, '1, cur_mac, 8'hff, MAGIC_COOKIE);
		pkt.push_back(OPT_PAD);
		pkt.push_back(OPT_PAD);
		add_option(OPT_MASK, 0);
		add_option(OPT_ROUTER, 2);
		add_option(OPT_SERVER, 6);
		add_option(OPT_MSG_TYPE, 3);
		add_option(OPT_MSG_TYPE, 1);
		add_option(OPT_MASK, 4);
		add_option(OPT_BOOT_FILE, 5);
		pkt.push_back(OPT_END);
		add_option(OPT_ROUTER, 4);
		send_packet('0);

		// last mark on the very first byte, then a header missing its last
		// cookie byte: both truncated
		pkt.delete();
		pkt.push_back(OP_REPLY);
		send_packet($urandom());
		build_header(OP_REPLY, cur_xid, $urandom(), $urandom(), cur_mac, 8'd0, MAGIC_COOKIE);
		void'(pkt.pop_back());
		send_packet($urandom());

		// exactly the header, empty options area
		build_header(OP_REPLY, cur_xid, '0, '0, cur_mac, 8'd0, MAGIC_COOKIE);
		send_packet('0);

		// check priority: each packet has its reported fault plus later ones
		build_header(OP_REPLY ^ 8'h80, cur_xid ^ 32'h1, $urandom(), $urandom(),
			cur_mac, 8'd1, MAGIC_COOKIE ^ 32'h1);
		send_packet($urandom());
		build_header(OP_REPLY, cur_xid ^ 32'h8000_0000, $urandom(), $urandom(),
			cur_mac ^ 48'h1, 8'd1, MAGIC_COOKIE ^ 32'h0100_0000);
		send_packet($urandom());
		build_header(OP_REPLY, cur_xid ^ 32'h0001_0000, $urandom(), $urandom(),
			cur_mac ^ 48'h8000_0000_0000, 8'd0, MAGIC_COOKIE);
		send_packet($urandom());
		build_header(OP_REPLY, cur_xid, $urandom(), $urandom(),
			cur_mac ^ 48'h0000_0100_0000, 8'd0, MAGIC_COOKIE);
		send_packet($urandom());

		// new random register values before the option-walk corners
		settle();
		cur_xid = $urandom();
		cur_mac = {16'($urandom()), 32'($urandom())};
		write_reg(CFG_XID, {16'($urandom()), cur_xid});
		write_reg(CFG_MAC, cur_mac);

		// mask code and length at the end of the options area, then its value
		// and bytes the block must ignore
		build_header(OP_REPLY, cur_xid, $urandom(), $urandom(), cur_mac, 8'd0, MAGIC_COOKIE);
		while (pkt.size() < PKT_BYTES - 2)
			pkt.push_back(OPT_PAD);
		add_option(OPT_MASK, 4);
		repeat (18) pkt.push_back(8'($urandom()));
		send_packet($urandom());

		// router value cut by the end of the packet
		build_header(OP_REPLY, cur_xid, $urandom(), $urandom(), cur_mac, 8'd0, MAGIC_COOKIE);
		add_option(OPT_SERVER, 4);
		add_option(OPT_ROUTER, 4);
		void'(pkt.pop_back());
		void'(pkt.pop_back());
		send_packet($urandom());

		// an option code as the final byte
		build_header(OP_REPLY, cur_xid, $urandom(), $urandom(), cur_mac, 8'd0, MAGIC_COOKIE);
		add_option(OPT_MSG_TYPE, 1);
		pkt.push_back(OPT_SERVER);
		send_packet($urandom());

		// zero-length message type, then a router option longer than the area
		build_header(OP_REPLY, cur_xid, $urandom(), $urandom(), cur_mac, 8'd0, MAGIC_COOKIE);
		add_option(OPT_MSG_TYPE, 0);
		add_option(OPT_ROUTER, 255);
		send_packet($urandom());

		// ---- random ----
		pkt_no = 0;
		while (sent_bytes < RANDOM_BYTES || pkt_no < MIN_RANDOM_REPLIES) begin
			// drained reconfiguration every dozen packets; also the sender
			// pause that waits out every pending result
			if (pkt_no % 12 == 0) begin
				settle();
				case ($urandom_range(2))
				0: cur_xid = '0;
				1: cur_xid = '1;
				default: cur_xid = $urandom();
				endcase
				case ($urandom_range(2))
				0: cur_mac = '0;
				1: cur_mac = '1;
				default: cur_mac = {16'($urandom()), 32'($urandom())};
				endcase
				write_reg(CFG_XID, {16'($urandom()), cur_xid});
				write_reg(CFG_MAC, cur_mac);
				if ($urandom_range(1))
					write_reg(CFG_SPARE, {16'($urandom()), 32'($urandom())});
			end

			// a gap-free stretch, then a sink hold-off with the sender
			// streaming short packets so a final byte backs up
			src_idle = ((pkt_no >= 14 && pkt_no < 22) || (pkt_no >= 30 && pkt_no < 34)) ?
				0 : IDLE_PCT;
			sink_idle = (pkt_no >= 14 && pkt_no < 22) ? 0 : IDLE_PCT;
			if (pkt_no == 30)
				sink_hold_req = 1'b1;

			kind = (pkt_no >= 30 && pkt_no < 34) ? 75 : $urandom_range(99);
			if (kind < 70) begin
				// well-formed reply, occasionally with flipped check bits
				build_header(
					($urandom_range(11) == 0) ? OP_REPLY ^ (8'd1 << $urandom_range(7)) :
						OP_REPLY,
					($urandom_range(11) == 0) ? cur_xid ^ (32'd1 << $urandom_range(31)) :
						cur_xid,
					$urandom(), $urandom(),
					($urandom_range(11) == 0) ? cur_mac ^ (48'd1 << $urandom_range(47)) :
						cur_mac,
					$urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 255)),
					($urandom_range(11) == 0) ?
						MAGIC_COOKIE ^ (32'd1 << $urandom_range(31)) : MAGIC_COOKIE);
				target = OPTS_START + (($urandom_range(7) == 0) ?
					$urandom_range(OPTION_BYTES + 1, OPTION_BYTES + 40) :
					$urandom_range(0, OPTION_BYTES));
				while (pkt.size() < target) begin
					case ($urandom_range(19))
					0, 1:       code = OPT_PAD;
					2, 3, 4:    code = OPT_MASK;
					5, 6, 7:    code = OPT_ROUTER;
					8, 9, 10:   code = OPT_MSG_TYPE;
					11, 12, 13: code = OPT_SERVER;
					14:         code = OPT_BOOT_FILE;
					15:         code = OPT_END;
					default:    code = 8'($urandom());
					endcase
					if (code == OPT_PAD || code == OPT_END) begin
						pkt.push_back(code);
					end else begin
						case ($urandom_range(7))
						0: n = $urandom_range(0, 6);
						1: n = $urandom_range(0, 255);
						default: n = (code == OPT_MSG_TYPE) ? 1 : 4;
						endcase
						add_option(code, n);
					end
				end
				// cutting to length can split the last value
				while (pkt.size() > target)
					void'(pkt.pop_back());
			end else if (kind < 85) begin
				build_header(OP_REPLY, cur_xid, $urandom(), $urandom(), cur_mac,
					8'($urandom()), MAGIC_COOKIE);
				n = $urandom_range(1, OPTS_START - 1);
				while (pkt.size() > n)
					void'(pkt.pop_back());
			end else begin
				pkt.delete();
				n = $urandom_range(1, PKT_BYTES + 20);
				repeat (n) pkt.push_back(8'($urandom()));
			end
			send_packet($urandom());
			pkt_no++;
		end

		src_idle = IDLE_PCT;
		settle();
		if (fail_count == 0)
			$display("tb_dhcp_reply_parser_core: PASS");
		else
			$display("tb_dhcp_reply_parser_core: FAIL");
		$finish;
	end

endmodule
